// ----- src/radix_page_table_manager_core_assert.svh -----
// Assertion macros for the page table manager. Each use names its own label.
`ifndef RADIX_PAGE_TABLE_MANAGER_CORE_ASSERT_SVH
`define RADIX_PAGE_TABLE_MANAGER_CORE_ASSERT_SVH
`ifndef SYNTH
`define RPTM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rptm check failed");
`define RPTM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rptm check failed");
`else
`define RPTM_ASSERT_ALWAYS(lbl, cond)
`define RPTM_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ----- src/rptm_pkg.sv -----
`timescale 1ns / 1ps
package rptm_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int LEVELS_DEF     = 4;
  localparam int NODE_ENTRIES   = 512;
  localparam int IDX_W          = 9;
  localparam int PAGE_SHIFT     = 12;
  localparam int ADDR_W         = 48;
  localparam int ENTRY_W        = 40;
  localparam int VAL_W          = 36;
  localparam int LIVE_W         = 10;
  localparam int VA_EXT_W       = 72;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_MISALIGN = 3'd2;
  localparam logic [2:0] ST_CONFLICT = 3'd3;
  localparam logic [2:0] ST_NONODE   = 3'd4;

  // Input command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_XLATE  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_XLATE  = 2'd2,
    OP_REJECT = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [15:0]       space_id;
    logic              page_size;
    logic [1:0]        page_flags;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        result_flags;
    logic [15:0]       result_space_id;
    logic              result_size;
    logic [ADDR_W-1:0] entry_addr;
  } rsp_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [2:0]        status;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [15:0]       space_id;
    logic              page_size;
    logic [1:0]        page_flags;
  } work_t;

  // Status of the back towards the front.
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage

// ----- src/rptm_front.sv -----
`timescale 1ns / 1ps
module rptm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rptm_pkg::req_t      request,
  input  rptm_pkg::back_stat_t bstat,
  output logic                wvalid,
  output rptm_pkg::work_t     witem
);
  import rptm_pkg::*;

  work_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  work_t      cls;
  logic       enq;
  logic       deq;
  logic       misal;

  // Classify the incoming item: reject unknown commands and misaligned inserts.
  always_comb begin
    misal = request.page_size
          ? ((request.virt_addr[20:0] != '0) || (request.phys_addr[20:0] != '0))
          : ((request.virt_addr[11:0] != '0) || (request.phys_addr[11:0] != '0));
    cls.virt_addr  = request.virt_addr;
    cls.phys_addr  = request.phys_addr;
    cls.space_id   = request.space_id;
    cls.page_size  = request.page_size;
    cls.page_flags = request.page_flags;
    cls.status     = ST_OK;
    unique case (request.cmd)
      CMD_INSERT: begin
        cls.op = misal ? OP_REJECT : OP_INSERT;
        cls.status = misal ? ST_MISALIGN : ST_OK;
      end
      CMD_REMOVE: cls.op = OP_REMOVE;
      CMD_XLATE:  cls.op = OP_XLATE;
      default: begin
        cls.op = OP_REJECT;
        cls.status = ST_NOTFOUND;
      end
    endcase
  end

  assign full   = (count == 2'd2) || bstat.clearing;
  assign enq    = push && !full;
  assign wvalid = (count != 2'd0);
  assign witem  = q[rd_ptr];
  assign deq    = bstat.take && wvalid;

  // Two-entry queue between the classifier and the walker.
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

// ----- src/rptm_back.sv -----
`timescale 1ns / 1ps
`include "radix_page_table_manager_core_assert.svh"
module rptm_back #(
  parameter int NODE_COUNT = rptm_pkg::NODE_COUNT_DEF,
  parameter int LEVELS     = rptm_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wvalid,
  input  rptm_pkg::work_t            witem,
  output rptm_pkg::back_stat_t       bstat,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rptm_pkg::ADDR_W-1:0] cfg_data,
  output logic                       empty,
  input  logic                       pop,
  output rptm_pkg::rsp_t             response
);
  import rptm_pkg::*;

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int LW    = $clog2(LEVELS);
  localparam int EAW   = NW + IDX_W;
  localparam int DEPTH = NODE_COUNT * NODE_ENTRIES;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_READ  = 8'b00000100,
    S_EVAL  = 8'b00001000,
    S_POP   = 8'b00010000,
    S_LINK  = 8'b00100000,
    S_FINAL = 8'b01000000,
    S_SPARE = 8'b10000000
  } state_t;

  state_t state, state_next;

  logic [ENTRY_W-1:0] ent_mem [DEPTH];
  logic [15:0]        sid_mem [DEPTH];
  logic [LIVE_W-1:0]  lc_mem  [NODE_COUNT];
  logic [NW-1:0]      fs_mem  [NODE_COUNT];

  logic [ENTRY_W-1:0] ent_q;
  logic [15:0]        sid_q;
  logic [LIVE_W-1:0]  lc_q;
  logic [NW-1:0]      fs_q;

  logic               ent_we, sid_we, lc_we;
  logic [EAW-1:0]     ent_waddr;
  logic [ENTRY_W-1:0] ent_wdata;
  logic [NW-1:0]      lc_waddr, lc_raddr;
  logic [LIVE_W-1:0]  lc_wdata;
  logic               fs_push;

  work_t              cur;
  logic [NW-1:0]      node, node_next;
  logic [LW-1:0]      lvl, lvl_next;
  logic [NW-1:0]      child, child_next;
  logic [LIVE_W-1:0]  lc, lc_next;
  logic [EAW-1:0]     clr;
  logic [NW:0]        fresh, fresh_next;
  logic [NW:0]        fdepth, fdepth_next;
  logic [ADDR_W-1:0]  table_base;
  logic               out_valid;
  rsp_t               out_item;
  logic               fin;
  rsp_t               fin_item;
  logic               take;

  logic [VA_EXT_W-1:0] va_ext;
  logic [IDX_W-1:0]    idx;
  logic [EAW-1:0]      slot_addr;
  logic                e_v, e_t, e_bad, at_target;
  logic [VAL_W-1:0]    e_val;

  // Index of the current level taken from the virtual address.
  always_comb begin
    va_ext = {{(VA_EXT_W-ADDR_W){1'b0}}, cur.virt_addr};
    idx = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (lvl == LW'(k)) begin
        idx = va_ext[PAGE_SHIFT + IDX_W*k +: IDX_W];
      end
    end
  end

  assign slot_addr = {node, idx};
  assign e_v       = ent_q[39];
  assign e_t       = ent_q[38];
  assign e_val     = ent_q[VAL_W-1:0];
  assign e_bad     = (e_val >= VAL_W'(NODE_COUNT));
  assign at_target = (lvl == LW'(cur.page_size));

  assign cfg_ready      = 1'b1;
  assign empty          = !out_valid;
  assign response       = out_item;
  assign bstat.clearing = (state == S_CLEAR);
  assign bstat.take     = take;

  // Walk sequencer: one memory read and one evaluation per level.
  always_comb begin
    state_next  = state;
    node_next   = node;
    lvl_next    = lvl;
    child_next  = child;
    lc_next     = lc;
    fresh_next  = fresh;
    fdepth_next = fdepth;
    ent_we      = 1'b0;
    ent_waddr   = slot_addr;
    ent_wdata   = '0;
    sid_we      = 1'b0;
    lc_we       = 1'b0;
    lc_waddr    = node;
    lc_wdata    = '0;
    lc_raddr    = node;
    fs_push     = 1'b0;
    fin         = 1'b0;
    fin_item    = '0;
    take        = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr;
        lc_we     = 1'b1;
        lc_waddr  = clr[NW-1:0];
        if (clr == EAW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (wvalid && !out_valid) begin
          take = 1'b1;
          node_next = '0;
          lvl_next  = LW'(LEVELS - 1);
          if (witem.op == OP_REJECT) begin
            fin = 1'b1;
            fin_item.status = witem.status;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        lc_next  = lc_q;
        lc_raddr = e_val[NW-1:0];
        if (cur.op == OP_INSERT) begin
          if (!at_target) begin
            if (!e_v) begin
              if (fdepth != '0) begin
                state_next = S_POP;
              end else if (fresh < (NW+1)'(NODE_COUNT)) begin
                child_next = fresh[NW-1:0];
                fresh_next = fresh + 1'b1;
                state_next = S_LINK;
              end else begin
                fin = 1'b1;
                fin_item.status = ST_NONODE;
              end
            end else if (e_t || e_bad) begin
              fin = 1'b1;
              fin_item.status = ST_CONFLICT;
            end else begin
              node_next  = e_val[NW-1:0];
              lvl_next   = lvl - 1'b1;
              state_next = S_READ;
            end
          end else if (e_v) begin
            if (!cur.page_size || e_t || e_bad) begin
              fin = 1'b1;
              fin_item.status = ST_CONFLICT;
            end else begin
              child_next = e_val[NW-1:0];
              state_next = S_FINAL;
            end
          end else begin
            ent_we    = 1'b1;
            ent_wdata = {1'b1, 1'b1, cur.page_flags, cur.phys_addr[ADDR_W-1:PAGE_SHIFT]};
            sid_we    = 1'b1;
            lc_we     = 1'b1;
            lc_wdata  = lc_q + 1'b1;
            fin = 1'b1;
            fin_item.status = ST_OK;
          end
        end else begin
          if (!e_v) begin
            fin = 1'b1;
            fin_item.status = ST_NOTFOUND;
          end else if (e_t) begin
            fin = 1'b1;
            fin_item.status       = ST_OK;
            fin_item.result_addr  = {e_val, {PAGE_SHIFT{1'b0}}};
            fin_item.result_flags = ent_q[37:36];
            if (cur.op == OP_REMOVE) begin
              fin_item.result_space_id = sid_q;
              fin_item.result_size     = (lvl == LW'(1));
              fin_item.entry_addr      = table_base +
                                         ADDR_W'({node, idx, 3'b000});
              ent_we   = 1'b1;
              lc_we    = 1'b1;
              lc_wdata = (lc_q != '0) ? (lc_q - 1'b1) : lc_q;
            end
          end else if (e_bad || (lvl == '0)) begin
            fin = 1'b1;
            fin_item.status = ST_NOTFOUND;
          end else begin
            node_next  = e_val[NW-1:0];
            lvl_next   = lvl - 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_POP: begin
        child_next  = fs_q;
        fdepth_next = fdepth - 1'b1;
        state_next  = S_LINK;
      end
      S_LINK: begin
        ent_we     = 1'b1;
        ent_wdata  = {1'b1, 1'b0, 2'b00, VAL_W'(child)};
        lc_we      = 1'b1;
        lc_wdata   = lc + 1'b1;
        node_next  = child;
        lvl_next   = lvl - 1'b1;
        state_next = S_READ;
      end
      S_FINAL: begin
        fin = 1'b1;
        if (lc_q != '0) begin
          fin_item.status = ST_CONFLICT;
        end else begin
          fin_item.status = ST_OK;
          ent_we    = 1'b1;
          ent_wdata = {1'b1, 1'b1, cur.page_flags, cur.phys_addr[ADDR_W-1:PAGE_SHIFT]};
          sid_we    = 1'b1;
          if (fdepth < (NW+1)'(NODE_COUNT)) begin
            fs_push     = 1'b1;
            fdepth_next = fdepth + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  // Table memories: at most one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_q <= ent_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (sid_we) begin
      sid_mem[slot_addr] <= cur.space_id;
    end
    sid_q <= sid_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (lc_we) begin
      lc_mem[lc_waddr] <= lc_wdata;
    end
    lc_q <= lc_mem[lc_raddr];
  end

  // Free node stack; the top is always being read.
  always_ff @(posedge clk) begin
    if (fs_push) begin
      fs_mem[fdepth[NW-1:0]] <= child;
    end
    fs_q <= fs_mem[NW'(fdepth - 1'b1)];
  end

  // Walk registers and the one-deep result register.
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= witem;
    end
    node  <= node_next;
    lvl   <= lvl_next;
    child <= child_next;
    lc    <= lc_next;
    if (fin) begin
      out_item <= fin_item;
    end
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      fresh      <= (NW+1)'(1);
      fdepth     <= '0;
      table_base <= '0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      fresh  <= fresh_next;
      fdepth <= fdepth_next;
      if (state == S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        table_base <= cfg_data;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RPTM_ASSERT_ALWAYS(a_fresh_bound, fresh <= (NW+1)'(NODE_COUNT))
  `RPTM_ASSERT_ALWAYS(a_free_bound, fdepth <= (NW+1)'(NODE_COUNT))
  `RPTM_ASSERT_IMPLY(a_take_free, take, !out_valid && (state == S_IDLE))
  `RPTM_ASSERT_IMPLY(a_pop_needs_stack, state == S_POP, $past(fdepth) != '0)

endmodule

// ----- src/radix_page_table_manager_core.sv -----
`timescale 1ns / 1ps
// Four-level radix page table manager with a pool of NODE_COUNT 512-entry nodes.
// Requests enter through a queue interface: drive request and raise push; the item
// is taken on a clock edge where full is low. Results leave the same way: while
// empty is low the oldest result is on response, and pop takes it.
// The table base register is written over cfg_valid/cfg_ready/cfg_data, and
// cfg_ready is always high; the user must write it only while the block is idle,
// which the block itself does not enforce. From acceptance an item passes through
// the front queue to the walker; each table level walked takes a registered
// memory read and then an evaluation. A node from the fresh pool adds a link
// step, one from the free stack a pop and a link step, a large-page reclaim a
// final check; a small-page insert allocates at most three nodes.
// The walker takes the next item only once the previous result has been popped.
// The front classifies and queues up to two items while the walker is busy.
// After reset the block clears its entry store, one entry per cycle, all
// NODE_COUNT*512 entries (32768 by default); full stays high meanwhile.
// A result that is not popped holds the walker; the front keeps accepting
// until its queue is full.
module radix_page_table_manager_core #(
  parameter int NODE_COUNT = rptm_pkg::NODE_COUNT_DEF,
  parameter int LEVELS     = rptm_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  rptm_pkg::req_t              request,
  output logic                        empty,
  input  logic                        pop,
  output rptm_pkg::rsp_t              response,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rptm_pkg::ADDR_W-1:0] cfg_data
);
  import rptm_pkg::*;

  logic       wvalid;
  work_t      witem;
  back_stat_t bstat;

  // Front: classification and queueing.
  rptm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .bstat  (bstat),
    .wvalid (wvalid),
    .witem  (witem)
  );

  // Back: table walker with its memories.
  rptm_back #(
    .NODE_COUNT(NODE_COUNT),
    .LEVELS    (LEVELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wvalid   (wvalid),
    .witem    (witem),
    .bstat    (bstat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .empty    (empty),
    .pop      (pop),
    .response (response)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rptm_pkg::*;

  localparam int NODES   = 64;
  localparam int ENTRIES = 512;
  localparam int RX_HOLD = 300;
  localparam logic [39:0] E_VALID = 40'h80_0000_0000;
  localparam logic [39:0] E_TERM  = 40'h40_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  req_t request = '0;
  logic full, empty, cfg_ready;
  rsp_t response;

  radix_page_table_manager_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .response(response),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow of the page table held by the block.
  logic [39:0] pte_shadow [NODES*ENTRIES];
  logic [15:0] sid_shadow [NODES*ENTRIES];
  int unsigned live_nodes [NODES];
  int unsigned free_nodes [$];
  int unsigned fresh_node;
  logic [ADDR_W-1:0] base_shadow;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int mismatches = 0;
  bit quiet_sender = 1'b0;
  bit hold_rx = 1'b0;
  int rx_hold_cycles = 0;
  bit calm = 1'b0;

  // Addresses that mappings have been made at, for reuse by later items.
  logic [ADDR_W-1:0] mapped_vas [$];

  function automatic int unsigned lvl_idx(logic [ADDR_W-1:0] va, int d);
    return 32'((va >> (12 + 9*d)) & 48'h1ff);
  endfunction

  function automatic bit take_node(output int unsigned n);
    if (free_nodes.size() > 0) begin
      n = free_nodes.pop_back();
      return 1'b1;
    end
    if (fresh_node < NODES) begin
      n = fresh_node;
      fresh_node++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] map_page(req_t r);
    logic [ADDR_W-1:0] mask;
    int tgt, d;
    int unsigned node, s, child;
    logic [39:0] e;
    mask = r.page_size ? 48'h1f_ffff : 48'hfff;
    tgt = r.page_size ? 1 : 0;
    node = 0;
    if ((r.virt_addr & mask) != 0 || (r.phys_addr & mask) != 0) return ST_MISALIGN;
    for (d = 3; d > tgt; d--) begin
      s = node*ENTRIES + lvl_idx(r.virt_addr, d);
      e = pte_shadow[s];
      if (!e[39]) begin
        if (!take_node(child)) return ST_NONODE;
        e = E_VALID | 40'(child);
        pte_shadow[s] = e;
        live_nodes[node]++;
      end
      if (e[38]) return ST_CONFLICT;
      if (e[35:0] >= NODES) return ST_CONFLICT;
      node = 32'(e[35:0]);
    end
    s = node*ENTRIES + lvl_idx(r.virt_addr, tgt);
    e = pte_shadow[s];
    if (e[39]) begin
      if (tgt != 1 || e[38]) return ST_CONFLICT;
      if (e[35:0] >= NODES) return ST_CONFLICT;
      child = 32'(e[35:0]);
      if (live_nodes[child] != 0) return ST_CONFLICT;
      if (free_nodes.size() < NODES) free_nodes.push_back(child);
    end else begin
      live_nodes[node]++;
    end
    pte_shadow[s] = E_VALID | E_TERM | (40'(r.page_flags) << 36) | 40'(r.phys_addr >> 12);
    sid_shadow[s] = r.space_id;
    return ST_OK;
  endfunction

  // Works out the response to one request and updates the shadow table.
  function automatic rsp_t table_response(req_t r);
    rsp_t o;
    int d;
    int unsigned node, idx, s;
    logic [39:0] e;
    bit hit;
    o = '0;
    if (r.cmd == CMD_INSERT) begin
      o.status = map_page(r);
      return o;
    end
    hit = 1'b0;
    node = 0;
    if (r.cmd != OP_REJECT) begin
      for (d = 3; d >= 0; d--) begin
        idx = lvl_idx(r.virt_addr, d);
        e = pte_shadow[node*ENTRIES + idx];
        if (!e[39]) break;
        if (e[38]) begin
          hit = 1'b1;
          break;
        end
        if (e[35:0] >= NODES) break;
        node = 32'(e[35:0]);
      end
    end
    if (!hit) begin
      o.status = ST_NOTFOUND;
      return o;
    end
    s = node*ENTRIES + idx;
    e = pte_shadow[s];
    o.status = ST_OK;
    o.result_addr = 48'(e[35:0]) << 12;
    o.result_flags = e[37:36];
    if (r.cmd == CMD_REMOVE) begin
      o.result_space_id = sid_shadow[s];
      o.result_size = (d == 1);
      o.entry_addr = base_shadow + 48'(node)*4096 + 48'(idx)*8;
      pte_shadow[s] = '0;
      if (live_nodes[node] > 0) live_nodes[node]--;
    end
    return o;
  endfunction

  // Addresses are mostly drawn from a small window so that walks share nodes.
  function automatic logic [ADDR_W-1:0] pick_va(bit big);
    logic [ADDR_W-1:0] va;
    if (mapped_vas.size() > 0 && $urandom_range(0, 2) == 0)
      return mapped_vas[$urandom_range(0, mapped_vas.size()-1)];
    va = {$urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, 1)),
          9'($urandom_range(0, 3)), 9'($urandom_range(0, 7)),
          9'($urandom_range(0, 15)), 12'h0};
    if ($urandom_range(0, 7) == 0) va = 48'({$urandom, $urandom});
    if (big) va[20:0] = '0;
    else if ($urandom_range(0, 19) == 0) va[11:0] = 12'($urandom);
    return va;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int pick;
    r.space_id = 16'($urandom);
    r.page_flags = 2'($urandom);
    r.page_size = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    r.cmd = pick < 45 ? CMD_INSERT : pick < 70 ? CMD_REMOVE : pick < 97 ? CMD_XLATE :
            OP_REJECT;
    r.virt_addr = pick_va(r.page_size);
    r.phys_addr = 48'({$urandom, $urandom});
    r.phys_addr[11:0] = '0;
    if (r.page_size) r.phys_addr[20:0] = '0;
    if ($urandom_range(0, 19) == 0) r.phys_addr[20:0] = 21'($urandom);
    if (r.cmd == CMD_INSERT) mapped_vas.push_back(r.virt_addr);
    if (mapped_vas.size() > 40) void'(mapped_vas.pop_front());
    return r;
  endfunction

  function automatic req_t make_req(logic [1:0] c, logic [ADDR_W-1:0] va,
                                    logic [ADDR_W-1:0] pa, bit big, logic [1:0] f,
                                    logic [15:0] sid);
    req_t r;
    r.cmd = c;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.page_size = big;
    r.page_flags = f;
    r.space_id = sid;
    return r;
  endfunction

  // Request driver: offers queued items, idling at random unless calm.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        expected_rsps.push_back(table_response(request));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && !quiet_sender &&
          (calm || $urandom_range(0, 99) >= 13)) begin
        push <= 1'b1;
        request <= pending_reqs[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Counts the cycles of the long receiver hold once it has been requested.
  always @(posedge clk) begin
    if (hold_rx && rx_hold_cycles < RX_HOLD) rx_hold_cycles <= rx_hold_cycles + 1;
  end

  // Response monitor: checks each popped item against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected response %h", response);
        end else begin
          want = expected_rsps.pop_front();
          if (response !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Response mismatch: expected st=%0d addr=%h fl=%0d sid=%h sz=%0d ea=%h, got st=%0d addr=%h fl=%0d sid=%h sz=%0d ea=%h",
                       want.status, want.result_addr, want.result_flags,
                       want.result_space_id, want.result_size, want.entry_addr,
                       response.status, response.result_addr, response.result_flags,
                       response.result_space_id, response.result_size,
                       response.entry_addr);
          end
        end
      end
      pop <= !(hold_rx && rx_hold_cycles < RX_HOLD) &&
             (calm || $urandom_range(0, 99) >= 13);
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_base(logic [ADDR_W-1:0] b);
    cfg_data <= b;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_shadow = b;
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    for (int i = 0; i < NODES*ENTRIES; i++) begin
      pte_shadow[i] = '0;
      sid_shadow[i] = '0;
    end
    foreach (live_nodes[i]) live_nodes[i] = 0;
    fresh_node = 1;
    base_shadow = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_base(48'hffff_ffff_f000);

    // Directed: both sizes, every command, misaligned, conflicts and reclaim.
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h0, 48'hffff_ffff_f000, 0, 2'd3, 16'hffff));
    pending_reqs.push_back(make_req(CMD_XLATE, 48'h0, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h0, 48'h1000, 0, 2'd1, 16'h1));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h123, 48'h1000, 0, 2'd1, 16'h1));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h20_0000, 48'h2000_0001, 1, 0, 0));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h0, 48'h20_0000, 1, 2'd2, 16'h55));
    pending_reqs.push_back(make_req(CMD_REMOVE, 48'h0, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h0, 48'hffff_ffe0_0000, 1, 2'd2, 16'h55));
    pending_reqs.push_back(make_req(CMD_XLATE, 48'h0_1234, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'h1000, 48'h3000, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_REMOVE, 48'h0, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_REMOVE, 48'h0, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_REJECT, 48'h0, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_INSERT, 48'hffff_ffff_f000, 48'h5000, 0, 1, 16'h8000));
    pending_reqs.push_back(make_req(CMD_REMOVE, 48'hffff_ffff_ffff, 48'h0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_XLATE, 48'hffff_ffff_ffff, 48'h0, 0, 0, 0));
    // Fill the pool with distinct top-level branches until nodes run out.
    for (int i = 1; i <= 24; i++)
      pending_reqs.push_back(make_req(CMD_INSERT, 48'(i) << 39, 48'h7000, 0, 2, 16'(i)));
    drain();

    set_base(48'h0);
    calm = 1'b1;
    random_phase(250);
    calm = 1'b0;
    // Hold the receiver off while the sender keeps offering items.
    hold_rx = 1'b1;
    random_phase(300);
    set_base(48'h1234_5678_9000);
    // Sender pauses part way through until all results are in, then carries on.
    repeat (20) pending_reqs.push_back(rand_req());
    repeat (30) @(posedge clk);
    quiet_sender = 1'b1;
    while (push || expected_rsps.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    quiet_sender = 1'b0;
    random_phase(330);
    set_base(48'h8000_0000_0000);
    random_phase(330);

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
